// ===== hw/rtl/qbf_pkg.sv =====
// Shared types and constants for the quartic bond force block.
// Holds the fixed-point limits, codes, pipeline stage map and stage payload.
// Depends on nothing.
package qbf_pkg;

    // Coefficient table geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int TAG_SUM_W   = 10;
    localparam int LANE_W      = 32;
    localparam int LANES       = 4;
    localparam int WORD_W      = LANE_W * LANES;

    // Q32.16 saturation limits.
    localparam logic signed [47:0] SMAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SMIN = 48'sh8000_0000_0000;

    // Item function codes.
    localparam logic [2:0] FUNC_R0   = 3'd0;
    localparam logic [2:0] FUNC_K2   = 3'd1;
    localparam logic [2:0] FUNC_K3   = 3'd2;
    localparam logic [2:0] FUNC_K4   = 3'd3;
    localparam logic [2:0] FUNC_EVAL = 3'd4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_NEWTON = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY = 2'd2;

    // Digit recurrence lengths and multiplier latency.
    localparam int SQ_BITS  = 33;
    localparam int DIV_BITS = 48;
    localparam int MUL_LAT  = 3;

    // Pipeline stage map: the stage at which each step lands.
    localparam int P_IN    = 0;
    localparam int P_SQ    = 1;
    localparam int P_SUM   = 2;
    localparam int P_ROOT0 = 3;
    localparam int P_DR    = P_ROOT0 + SQ_BITS;
    localparam int P_M1    = P_DR + MUL_LAT + 1;
    localparam int P_M2    = P_M1 + MUL_LAT + 1;
    localparam int P_M3    = P_M2 + MUL_LAT + 1;
    localparam int P_SCL   = P_M3 + 1;
    localparam int P_DE1   = P_SCL + 1;
    localparam int P_DE    = P_DE1 + 1;
    localparam int P_M4    = P_M3 + MUL_LAT + 1;
    localparam int P_EN1   = P_M4 + 1;
    localparam int P_EN    = P_EN1 + 1;
    localparam int P_DIV0  = P_M4 + 1;
    localparam int P_FS    = P_DIV0 + DIV_BITS;
    localparam int P_LAST  = P_FS + MUL_LAT;
    localparam int NSTG    = P_LAST + 1;

    // Multiplier slots.
    localparam int MUL_DR2 = 0;
    localparam int MUL_T2  = 1;
    localparam int MUL_DR3 = 2;
    localparam int MUL_T3  = 3;
    localparam int MUL_E2  = 4;
    localparam int MUL_DR4 = 5;
    localparam int MUL_T4  = 6;
    localparam int MUL_E3  = 7;
    localparam int MUL_E4  = 8;
    localparam int MUL_FX  = 9;
    localparam int MUL_FY  = 10;
    localparam int MUL_FZ  = 11;
    localparam int MUL_N   = 12;

    // Payload carried down the bond pipeline.
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic signed [31:0] r0;
        logic signed [31:0] k2;
        logic signed [31:0] k3;
        logic signed [31:0] k4;
        logic               app_a;
        logic               app_b;
        logic [65:0]        sqx;
        logic [65:0]        sqy;
        logic [65:0]        sqz;
        logic [65:0]        rad;
        logic [33:0]        rem;
        logic [32:0]        root;
        logic               rzero;
        logic signed [47:0] dr;
        logic signed [47:0] dr2;
        logic signed [47:0] dr3;
        logic signed [47:0] dr4;
        logic signed [47:0] t2;
        logic signed [47:0] t3;
        logic signed [47:0] t4;
        logic signed [47:0] e2;
        logic signed [47:0] e3;
        logic signed [47:0] e4;
        logic signed [47:0] sa;
        logic signed [47:0] sb;
        logic signed [47:0] sc;
        logic signed [47:0] de1;
        logic signed [47:0] de;
        logic signed [47:0] en1;
        logic signed [47:0] en;
        logic [47:0]        dnum;
        logic [32:0]        drem;
        logic [47:0]        quo;
        logic               ovf;
        logic               depos;
        logic signed [47:0] fs;
    } bond_t;

endpackage

// ===== hw/rtl/quartic_bond_force.sv =====
// Throughput: one item per cycle unless the output stalls; the chain of a 33-step square
// root, twelve three-stage multipliers and a 48-step divider is fully pipelined and stalls
// as one. Load items write one coefficient lane and give no result. Reset (aresetn low,
// synchronous) empties the pipeline and sets the configuration registers to defaults;
// tables hold garbage until loaded.
// Depends on qbf_pkg and qbf_mulq.
module quartic_bond_force
    import qbf_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_func,
    input  logic [15:0]              s_index_a,
    input  logic [15:0]              s_index_b,
    input  logic [8:0]               s_tag_a,
    input  logic [8:0]               s_tag_b,
    input  logic signed [31:0]       s_pos_a_x,
    input  logic signed [31:0]       s_pos_a_y,
    input  logic signed [31:0]       s_pos_a_z,
    input  logic signed [31:0]       s_pos_b_x,
    input  logic signed [31:0]       s_pos_b_y,
    input  logic signed [31:0]       s_pos_b_z,
    input  logic signed [31:0]       s_coef_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [47:0]       m_force_x,
    output logic signed [47:0]       m_force_y,
    output logic signed [47:0]       m_force_z,
    output logic signed [47:0]       m_force_scale,
    output logic signed [47:0]       m_energy,
    output logic                     m_apply_a,
    output logic                     m_apply_b
);

    // Saturate a wide signed sum to the Q32.16 range.
    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        if (v > 50'(SMAX)) begin
            return SMAX;
        end else if (v < 50'(SMIN)) begin
            return SMIN;
        end
        return 48'(v);
    endfunction

    // One digit of the square root recurrence.
    function automatic bond_t sqrt_step(input bond_t s);
        bond_t       o;
        logic [35:0] rem_t;
        logic [35:0] trial;
        o     = s;
        rem_t = {s.rem, s.rad[65:64]};
        trial = {1'b0, s.root, 2'b01};
        if (rem_t >= trial) begin
            o.rem  = 34'(rem_t - trial);
            o.root = {s.root[31:0], 1'b1};
        end else begin
            o.rem  = rem_t[33:0];
            o.root = {s.root[31:0], 1'b0};
        end
        o.rad = {s.rad[63:0], 2'b00};
        return o;
    endfunction

    // Divider setup: magnitude and sign of the derivative, overflow test, first remainder.
    function automatic bond_t div_prep(input bond_t s);
        bond_t       o;
        logic [47:0] mde;
        o     = s;
        mde   = s.de[47] ? 48'(-s.de) : 48'(s.de);
        o.ovf   = (33'(mde[47:31]) >= s.root);
        o.drem  = 33'(mde[47:32]);
        o.dnum  = {mde[31:0], 16'd0};
        o.quo   = '0;
        o.depos = (s.de > 48'sd0);
        return o;
    endfunction

    // One quotient bit of the restoring divider.
    function automatic bond_t div_step(input bond_t s);
        bond_t       o;
        logic [33:0] rem_t;
        o     = s;
        rem_t = {s.drem, s.dnum[47]};
        if (rem_t >= {1'b0, s.root}) begin
            o.drem = 33'(rem_t - {1'b0, s.root});
            o.quo  = {s.quo[46:0], 1'b1};
        end else begin
            o.drem = rem_t[32:0];
            o.quo  = {s.quo[46:0], 1'b0};
        end
        o.dnum = {s.dnum[46:0], 1'b0};
        return o;
    endfunction

    logic                  newton_reg;
    logic [16:0]           local_count_reg;
    logic                  energy_en_reg;
    logic                  adv;
    logic                  in_acc;
    logic [TAG_SUM_W-1:0]  tag_sum;
    logic                  tag_ok;
    logic [ADDR_W-1:0]     addr;
    logic [WORD_W-1:0]     mem [TABLE_DEPTH];
    logic [WORD_W-1:0]     rd_reg;
    logic                  ok_reg;
    bond_t                 pipe_reg  [NSTG];
    bond_t                 pipe_next [NSTG];
    logic [NSTG-1:0]       vld_reg;
    logic signed [47:0]    mul_a [MUL_N];
    logic signed [47:0]    mul_b [MUL_N];
    logic signed [47:0]    mul_p [MUL_N];
    logic                  m_valid_reg;
    logic signed [47:0]    fx_reg, fy_reg, fz_reg, fs_reg, en_reg;
    logic                  apa_reg, apb_reg;

    // The whole pipeline moves when the output beat is free or being taken.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign in_acc  = s_valid && adv;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            newton_reg      <= 1'b0;
            local_count_reg <= '0;
            energy_en_reg   <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_NEWTON: newton_reg      <= cfg_data[0];
                CFG_LOCAL:  local_count_reg <= cfg_data;
                CFG_ENERGY: energy_en_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Coefficient table: one word per tag sum, one lane per coefficient.
    assign tag_sum = TAG_SUM_W'(s_tag_a) + TAG_SUM_W'(s_tag_b);
    assign tag_ok  = (32'(tag_sum) < 32'(TABLE_DEPTH));
    assign addr    = ADDR_W'(tag_sum);

    always_ff @(posedge aclk) begin
        if (in_acc && tag_ok && (s_func < FUNC_EVAL)) begin
            mem[addr][32'(s_func[1:0]) * LANE_W +: LANE_W] <= s_coef_value;
        end
        if (adv) begin
            rd_reg <= mem[addr];
            ok_reg <= tag_ok;
        end
    end

    // Stage inputs: stage zero takes the input beat; each later stage takes the previous payload and does its step.
    always_comb begin
        pipe_next[P_IN]       = pipe_reg[P_IN];
        pipe_next[P_IN].dx    = 33'(s_pos_a_x) - 33'(s_pos_b_x);
        pipe_next[P_IN].dy    = 33'(s_pos_a_y) - 33'(s_pos_b_y);
        pipe_next[P_IN].dz    = 33'(s_pos_a_z) - 33'(s_pos_b_z);
        pipe_next[P_IN].app_a = newton_reg || (17'(s_index_a) < local_count_reg);
        pipe_next[P_IN].app_b = newton_reg || (17'(s_index_b) < local_count_reg);
        for (int p = 1; p < NSTG; p++) begin
            pipe_next[p] = pipe_reg[p-1];
            if (p == P_SQ) begin
                pipe_next[p].r0  = ok_reg ? rd_reg[0*LANE_W +: LANE_W] : '0;
                pipe_next[p].k2  = ok_reg ? rd_reg[1*LANE_W +: LANE_W] : '0;
                pipe_next[p].k3  = ok_reg ? rd_reg[2*LANE_W +: LANE_W] : '0;
                pipe_next[p].k4  = ok_reg ? rd_reg[3*LANE_W +: LANE_W] : '0;
                pipe_next[p].sqx = 66'(pipe_reg[p-1].dx[32] ? 33'(-pipe_reg[p-1].dx)
                                                             : 33'(pipe_reg[p-1].dx)) *
                                   66'(pipe_reg[p-1].dx[32] ? 33'(-pipe_reg[p-1].dx)
                                                             : 33'(pipe_reg[p-1].dx));
                pipe_next[p].sqy = 66'(pipe_reg[p-1].dy[32] ? 33'(-pipe_reg[p-1].dy)
                                                             : 33'(pipe_reg[p-1].dy)) *
                                   66'(pipe_reg[p-1].dy[32] ? 33'(-pipe_reg[p-1].dy)
                                                             : 33'(pipe_reg[p-1].dy));
                pipe_next[p].sqz = 66'(pipe_reg[p-1].dz[32] ? 33'(-pipe_reg[p-1].dz)
                                                             : 33'(pipe_reg[p-1].dz)) *
                                   66'(pipe_reg[p-1].dz[32] ? 33'(-pipe_reg[p-1].dz)
                                                             : 33'(pipe_reg[p-1].dz));
            end
            if (p == P_SUM) begin
                pipe_next[p].rad  = pipe_reg[p-1].sqx + pipe_reg[p-1].sqy +
                                    pipe_reg[p-1].sqz;
                pipe_next[p].rem  = '0;
                pipe_next[p].root = '0;
            end
            if ((p >= P_ROOT0) && (p < P_DR)) begin
                pipe_next[p] = sqrt_step(pipe_reg[p-1]);
            end
            if (p == P_DR) begin
                pipe_next[p].dr = 48'($signed({2'b00, pipe_reg[p-1].root}) -
                                      35'(pipe_reg[p-1].r0));
                pipe_next[p].rzero = (pipe_reg[p-1].root == '0);
            end
            if (p == P_M1) begin
                pipe_next[p].dr2 = mul_p[MUL_DR2];
                pipe_next[p].t2  = mul_p[MUL_T2];
            end
            if (p == P_M2) begin
                pipe_next[p].dr3 = mul_p[MUL_DR3];
                pipe_next[p].t3  = mul_p[MUL_T3];
                pipe_next[p].e2  = mul_p[MUL_E2];
            end
            if (p == P_M3) begin
                pipe_next[p].dr4 = mul_p[MUL_DR4];
                pipe_next[p].t4  = mul_p[MUL_T4];
                pipe_next[p].e3  = mul_p[MUL_E3];
            end
            if (p == P_SCL) begin
                pipe_next[p].sa = sat48(50'(pipe_reg[p-1].t2) * 50'sd2);
                pipe_next[p].sb = sat48(50'(pipe_reg[p-1].t3) * 50'sd3);
                pipe_next[p].sc = sat48(50'(pipe_reg[p-1].t4) * 50'sd4);
            end
            if (p == P_DE1) begin
                pipe_next[p].de1 = sat48(50'(pipe_reg[p-1].sa) + 50'(pipe_reg[p-1].sb));
            end
            if (p == P_DE) begin
                pipe_next[p].de = sat48(50'(pipe_reg[p-1].de1) + 50'(pipe_reg[p-1].sc));
            end
            if (p == P_M4) begin
                pipe_next[p]    = div_prep(pipe_reg[p-1]);
                pipe_next[p].e4 = mul_p[MUL_E4];
            end
            if ((p >= P_DIV0) && (p < P_FS)) begin
                pipe_next[p] = div_step(pipe_reg[p-1]);
            end
            if (p == P_EN1) begin
                pipe_next[p].en1 = sat48(50'(pipe_reg[p-1].e2) + 50'(pipe_reg[p-1].e3));
            end
            if (p == P_EN) begin
                pipe_next[p].en = energy_en_reg ?
                    sat48(50'(pipe_reg[p-1].en1) + 50'(pipe_reg[p-1].e4)) : 48'sd0;
            end
            if (p == P_FS) begin
                if (pipe_reg[p-1].rzero) begin
                    pipe_next[p].fs = 48'sd0;
                end else if (pipe_reg[p-1].ovf) begin
                    pipe_next[p].fs = pipe_reg[p-1].depos ? -SMAX : SMAX;
                end else begin
                    pipe_next[p].fs = pipe_reg[p-1].depos ? -$signed(pipe_reg[p-1].quo)
                                                          : $signed(pipe_reg[p-1].quo);
                end
            end
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int p = 0; p < NSTG; p++) begin
                pipe_reg[p] <= pipe_next[p];
            end
        end
    end

    // Beat valid chain; only evaluate items enter it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], in_acc && (s_func == FUNC_EVAL)};
        end
    end

    // Multiplier operand routing.
    assign mul_a[MUL_DR2] = pipe_reg[P_DR].dr;
    assign mul_b[MUL_DR2] = pipe_reg[P_DR].dr;
    assign mul_a[MUL_T2]  = 48'(pipe_reg[P_DR].k2);
    assign mul_b[MUL_T2]  = pipe_reg[P_DR].dr;
    assign mul_a[MUL_DR3] = pipe_reg[P_M1].dr2;
    assign mul_b[MUL_DR3] = pipe_reg[P_M1].dr;
    assign mul_a[MUL_T3]  = 48'(pipe_reg[P_M1].k3);
    assign mul_b[MUL_T3]  = pipe_reg[P_M1].dr2;
    assign mul_a[MUL_E2]  = 48'(pipe_reg[P_M1].k2);
    assign mul_b[MUL_E2]  = pipe_reg[P_M1].dr2;
    assign mul_a[MUL_DR4] = pipe_reg[P_M2].dr3;
    assign mul_b[MUL_DR4] = pipe_reg[P_M2].dr;
    assign mul_a[MUL_T4]  = 48'(pipe_reg[P_M2].k4);
    assign mul_b[MUL_T4]  = pipe_reg[P_M2].dr3;
    assign mul_a[MUL_E3]  = 48'(pipe_reg[P_M2].k3);
    assign mul_b[MUL_E3]  = pipe_reg[P_M2].dr3;
    assign mul_a[MUL_E4]  = 48'(pipe_reg[P_M3].k4);
    assign mul_b[MUL_E4]  = pipe_reg[P_M3].dr4;
    assign mul_a[MUL_FX]  = 48'(pipe_reg[P_FS].dx);
    assign mul_b[MUL_FX]  = pipe_reg[P_FS].fs;
    assign mul_a[MUL_FY]  = 48'(pipe_reg[P_FS].dy);
    assign mul_b[MUL_FY]  = pipe_reg[P_FS].fs;
    assign mul_a[MUL_FZ]  = 48'(pipe_reg[P_FS].dz);
    assign mul_b[MUL_FZ]  = pipe_reg[P_FS].fs;

    // Multiplier bank.
    for (genvar i = 0; i < MUL_N; i++) begin : g_mul
        qbf_mulq u_mulq (
            .aclk (aclk),
            .en   (adv),
            .a    (mul_a[i]),
            .b    (mul_b[i]),
            .p    (mul_p[i])
        );
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vld_reg[P_LAST];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fx_reg  <= mul_p[MUL_FX];
            fy_reg  <= mul_p[MUL_FY];
            fz_reg  <= mul_p[MUL_FZ];
            fs_reg  <= pipe_reg[P_LAST].fs;
            en_reg  <= pipe_reg[P_LAST].en;
            apa_reg <= pipe_reg[P_LAST].app_a;
            apb_reg <= pipe_reg[P_LAST].app_b;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_force_x     = fx_reg;
    assign m_force_y     = fy_reg;
    assign m_force_z     = fz_reg;
    assign m_force_scale = fs_reg;
    assign m_energy      = en_reg;
    assign m_apply_a     = apa_reg;
    assign m_apply_b     = apb_reg;

endmodule

// ===== hw/rtl/qbf_mulq.sv =====
// Three-stage saturating Q32.16 multiplier: (a*b) >> 16, truncated toward zero.
// Built from four 24x24 partial products. Depends on qbf_pkg.
module qbf_mulq
    import qbf_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic signed [47:0] a,
    input  logic signed [47:0] b,
    output logic signed [47:0] p
);

    logic [47:0] ma;
    logic [47:0] mb;
    logic [47:0] pp0_reg, pp1_reg, pp2_reg, pp3_reg;
    logic        neg1_reg;
    logic [47:0] pp0b_reg, pp3b_reg;
    logic [48:0] mid_reg;
    logic        neg2_reg;
    logic [95:0] tot;
    logic [46:0] q;
    logic signed [47:0] p_next;
    logic signed [47:0] p_reg;

    // Operand magnitudes; the most negative value maps to 2^47.
    assign ma = a[47] ? 48'(-a) : 48'(a);
    assign mb = b[47] ? 48'(-b) : 48'(b);

    // Stage one: partial products.
    always_ff @(posedge aclk) begin
        if (en) begin
            pp0_reg  <= 48'(ma[23:0]) * 48'(mb[23:0]);
            pp1_reg  <= 48'(ma[23:0]) * 48'(mb[47:24]);
            pp2_reg  <= 48'(ma[47:24]) * 48'(mb[23:0]);
            pp3_reg  <= 48'(ma[47:24]) * 48'(mb[47:24]);
            neg1_reg <= a[47] ^ b[47];
        end
    end

    // Stage two: fold the cross terms.
    always_ff @(posedge aclk) begin
        if (en) begin
            mid_reg  <= 49'(pp1_reg) + 49'(pp2_reg);
            pp0b_reg <= pp0_reg;
            pp3b_reg <= pp3_reg;
            neg2_reg <= neg1_reg;
        end
    end

    // Stage three: full product, scale, clamp and sign.
    always_comb begin
        tot = {pp3b_reg, 48'd0} + {23'd0, mid_reg, 24'd0} + {48'd0, pp0b_reg};
        q   = (tot[95:63] != '0) ? SMAX[46:0] : tot[62:16];
        p_next = neg2_reg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule
